>>> sv/midi_voice_allocator_unit_macros.svh
// Assertion macros shared by the voice allocator checker.
// Depends on nothing; the user supplies clk_i and rst_ni in scope.
`ifndef MIDI_VOICE_ALLOCATOR_UNIT_MACROS_SVH
`define MIDI_VOICE_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define MVA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define MVA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/mva_pkg.sv
// Shared types and constants of the MIDI voice allocator.
// Holds the voice entry type and the phase increment table builder; no dependencies.
`timescale 1ns / 1ps

package mva_pkg;

  localparam int NOTE_W      = 7;
  localparam int VEL_W       = 7;
  localparam int BASE_W      = 11;
  localparam int NOTE_COUNT  = 128;
  localparam int NOTES_PER_OCTAVE = 12;

  // Base frequency of note 0 times 10^10, and the fixed-point scale chain.
  localparam logic [63:0] BASE_FREQ_E10  = 64'd81757989156;
  localparam logic [63:0] PRE_SCALE      = 64'd100000000;
  localparam logic [63:0] SAMPLE_RATE_HZ = 64'd32000;
  localparam logic [63:0] POST_DIVISOR   = 64'd100 * SAMPLE_RATE_HZ * 64'd16777216;
  localparam logic [63:0] BASE_MAX       = 64'd2047;

  // 2^(s/12) in Q24, semitone 11 first.
  localparam logic [11:0][24:0] SEMITONE_RATIO_Q24 = {
    25'd31671166, 25'd29893600, 25'd28215802, 25'd26632170,
    25'd25137421, 25'd23726566, 25'd22394897, 25'd21137968,
    25'd19951585, 25'd18831788, 25'd17774841, 25'd16777216
  };

  typedef logic [NOTE_COUNT-1:0][BASE_W-1:0] inc_rom_t;

  typedef struct packed {
    logic              active;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
  } voice_entry_t;

  // Elaboration-time table: saturated base increment for every note.
  function automatic inc_rom_t build_inc_rom(input logic [63:0] points);
    inc_rom_t    rom;
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] v;
    int          n;
    int          s;
    int          o;
    for (n = 0; n < NOTE_COUNT; n++) begin
      s = n % NOTES_PER_OCTAVE;
      o = n / NOTES_PER_OCTAVE;
      p = 64'(SEMITONE_RATIO_Q24[s]) * BASE_FREQ_E10;
      q = p / PRE_SCALE;
      v = ((q << o) * points) / POST_DIVISOR;
      if (v > BASE_MAX) begin
        v = BASE_MAX;
      end
      rom[n] = v[BASE_W-1:0];
    end
    return rom;
  endfunction

endpackage

>>> sv/midi_voice_allocator_unit.sv
// Top level of the MIDI polyphonic voice allocator.
// Depends on mva_pkg for the voice entry type and the increment table.
//
// Usage:
//  - Input channel (in_valid_i / in_ready_o) carries one note event item:
//    note_number_i and key_velocity_i. Nonzero velocity is a note-on, zero
//    a note-off.
//  - Output channel (out_valid_o / out_ready_i) carries one result item per
//    event: voice index, found flag, note-on flag and three phase increments.
//  - Voice state sits in a single-port synchronous store, one entry per voice,
//    read one entry a cycle. A note-on claims the lowest free voice, a
//    note-off frees the lowest active voice holding that note.
//  - A scan reads the voices in order from voice 0 and stops at the voice
//    that hits (or at VOICE_COUNT-1 on a miss); the result is then loaded
//    into the output register. The next item can be taken once the result
//    is registered, not while the scan of the current item is running.
//  - A finished result waits in the output register; a new item may be taken
//    while it waits. A scan that ends while the register is still full holds
//    until the receiver takes the old result.
//  - Reset clears all voices at once through per-entry valid bits; an entry
//    that was never written reads as free.
`timescale 1ns / 1ps

module midi_voice_allocator_unit import mva_pkg::*; #(
  parameter int VOICE_COUNT       = 8,
  parameter int WAVE_TABLE_POINTS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [NOTE_W-1:0] note_number_i,
  input  logic [VEL_W-1:0]  key_velocity_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        voice_index_o,
  output logic              found_o,
  output logic              is_note_on_o,
  output logic [10:0]       base_increment_o,
  output logic [11:0]       double_increment_o,
  output logic [9:0]        half_increment_o
);

  localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  // Base increment per note, worked out at elaboration.
  localparam inc_rom_t BASE_ROM = build_inc_rom(64'(WAVE_TABLE_POINTS));

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state_q, state_d;

  // Event held for the duration of the scan.
  logic [NOTE_W-1:0] note_q;
  logic [VEL_W-1:0]  vel_q;

  // Voice store and its per-entry valid bits.
  voice_entry_t            voice_mem [VOICE_COUNT];
  logic [VOICE_COUNT-1:0]  entry_valid_q;
  voice_entry_t            rd_data_q;
  logic                    rd_valid_q;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  logic                    wr_en;
  voice_entry_t            wr_data;

  // Index of the entry whose data sits in rd_data_q.
  logic [IDX_W-1:0] scan_idx_q, scan_idx_d;

  voice_entry_t entry;
  logic         is_on;
  logic         hit;
  logic         last;
  logic         slot_free;
  logic         accept;
  logic         finish;
  logic         advance;
  logic [31:0]  idx_wide;

  // Output register.
  logic              out_valid_q;
  logic [2:0]        out_idx_q;
  logic              out_found_q;
  logic              out_on_q;
  logic [BASE_W-1:0] out_base_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // An entry never written since reset reads as an empty voice.
  assign entry     = rd_valid_q ? rd_data_q : '0;
  assign is_on     = (vel_q != '0);
  assign hit       = is_on ? !entry.active : (entry.active && (entry.note == note_q));
  assign last      = (scan_idx_q == IDX_W'(VOICE_COUNT - 1));
  assign slot_free = !out_valid_q || out_ready_i;

  // Finish on a hit or after the last voice, once the output slot is free.
  assign finish  = (state_q == ST_SCAN) && (hit || last) && slot_free;
  assign advance = (state_q == ST_SCAN) && !hit && !last;

  // Fetch voice 0 on acceptance, then the next voice each cycle of the scan.
  // The write of a finished item lands before the next item can be accepted,
  // so a read never overlaps a pending write of the same entry.
  assign rd_en   = accept || advance;
  assign rd_addr = accept ? '0 : (scan_idx_q + 1'b1);

  // Claim stores the event; release clears the entry to zero.
  assign wr_en   = finish && hit;
  assign wr_data = is_on ? voice_entry_t'{active: 1'b1, note: note_q, velocity: vel_q}
                         : voice_entry_t'('0);

  assign idx_wide = 32'(scan_idx_q);

  always_comb begin
    state_d    = state_q;
    scan_idx_d = scan_idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d    = ST_SCAN;
          scan_idx_d = '0;
        end
      end
      ST_SCAN: begin
        if (finish) begin
          state_d = ST_IDLE;
        end else if (advance) begin
          scan_idx_d = scan_idx_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      scan_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      scan_idx_q <= scan_idx_d;
    end
  end

  // Hold the event while scanning.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      note_q <= note_number_i;
      vel_q  <= key_velocity_i;
    end
  end

  // Voice store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      voice_mem[scan_idx_q] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= voice_mem[rd_addr];
    end
  end

  // Valid bits: reset marks every voice as empty at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
      rd_valid_q    <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_valid_q[scan_idx_q] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= entry_valid_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the result; drop the index on a miss and the increments on a miss or a note-off.
  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_idx_q   <= hit ? idx_wide[2:0] : 3'd0;
      out_found_q <= hit;
      out_on_q    <= is_on;
      out_base_q  <= (hit && is_on) ? BASE_ROM[note_q] : '0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign voice_index_o      = out_idx_q;
  assign found_o            = out_found_q;
  assign is_note_on_o       = out_on_q;
  assign base_increment_o   = out_base_q;
  assign double_increment_o = {out_base_q, 1'b0};
  assign half_increment_o   = out_base_q[BASE_W-1:1];

endmodule

>>> sv/mva_checker.sv
// Port-level checker for the MIDI voice allocator, bound to the top level.
// Depends on midi_voice_allocator_unit_macros.svh for the assertion macros.
`timescale 1ns / 1ps
`include "midi_voice_allocator_unit_macros.svh"

module mva_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [6:0]  note_number_i,
  input logic [6:0]  key_velocity_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  voice_index_o,
  input logic        found_o,
  input logic        is_note_on_o,
  input logic [10:0] base_increment_o,
  input logic [11:0] double_increment_o,
  input logic [9:0]  half_increment_o
);

  logic in_seen;
  assign in_seen = in_valid_i && in_ready_o && (note_number_i == note_number_i)
                   && (key_velocity_i == key_velocity_i);

  // Hold a stalled result.
  `MVA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(voice_index_o) && $stable(found_o) && $stable(base_increment_o), "stalled result changed")

  // A miss reports voice zero and no increments.
  `MVA_ASSERT_NOW(a_miss_zero, out_valid_o && !found_o, voice_index_o == 3'd0 && base_increment_o == 11'd0, "miss carries index or increment")

  // A note-off never carries increments.
  `MVA_ASSERT_NOW(a_off_zero, out_valid_o && !is_note_on_o, base_increment_o == 11'd0 && double_increment_o == 12'd0, "note-off carries increment")

  // Double and half increments follow from the base increment.
  `MVA_ASSERT_NOW(a_inc_rel, out_valid_o, double_increment_o[11:1] == base_increment_o && !double_increment_o[0] && half_increment_o == base_increment_o[10:1], "derived increments disagree")

  // An accepted item never finds the next cycle still ready.
  `MVA_ASSERT_NEXT(a_busy_after_accept, in_seen, !in_ready_o, "ready straight after acceptance")

endmodule

bind midi_voice_allocator_unit mva_checker u_mva_checker (.*);
